// ----- hdl/lom_pkg.sv -----
// package for the limit order matcher: item types, codes, slot record and
// scan unit control struct; no dependencies
package lom_pkg;

  localparam int unsigned OrderSlotsDefault = 256;
  localparam int unsigned CountOutW = 9;
  localparam logic [CountOutW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    FUNC_BUY    = 2'd0,
    FUNC_SELL   = 2'd1,
    FUNC_CANCEL = 2'd2,
    FUNC_UNUSED = 2'd3   // ignored, only the counts are reported
  } lom_func_e;

  typedef enum logic [1:0] {
    STATUS_ADD_DONE       = 2'd0,
    STATUS_CANCEL_FOUND   = 2'd1,
    STATUS_CANCEL_MISSING = 2'd2,
    STATUS_BOOK_FULL      = 2'd3
  } lom_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_RESULT
  } lom_state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] order_id;
    logic [31:0] limit_price;
    logic [31:0] order_quantity;
  } lom_in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [31:0]          filled_quantity;
    logic [31:0]          rested_quantity;
    logic [CountOutW-1:0] trade_count;
    logic [CountOutW-1:0] bid_count;
    logic [CountOutW-1:0] ask_count;
  } lom_out_item_t;

  // resting order fields, quantity excluded (kept in its own array)
  typedef struct packed {
    logic        side;     // 1 = sell
    logic [31:0] price;
    logic [63:0] order_id;
    logic [31:0] arrival;
  } lom_slot_rec_t;

  typedef struct packed {
    logic clear;    // start of a new pass
    logic cmp_en;   // compare stage holds a slot
    logic cancel;   // search by id instead of price
    logic sell;     // incoming side
  } lom_scan_ctrl_t;

endpackage

// ----- hdl/lom_slot_mem.sv -----
// slot storage for the limit order matcher: record array plus quantity array,
// one write and one registered read per cycle; depends on lom_pkg
module lom_slot_mem #(
  parameter int unsigned Depth = lom_pkg::OrderSlotsDefault,
  parameter int unsigned IdxW  = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  logic [IdxW-1:0]       rd_addr_i,
  output lom_pkg::lom_slot_rec_t rd_rec_o,
  output logic [31:0]           rd_qty_o,
  input  logic [IdxW-1:0]       wr_addr_i,
  input  logic                  wr_rec_en_i,
  input  lom_pkg::lom_slot_rec_t wr_rec_i,
  input  logic                  wr_qty_en_i,
  input  logic [31:0]           wr_qty_i
);
  import lom_pkg::*;

  lom_slot_rec_t rec_mem [Depth];
  logic [31:0]   qty_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_rec_en_i) begin
      rec_mem[wr_addr_i] <= wr_rec_i;
    end
    if (wr_qty_en_i) begin
      qty_mem[wr_addr_i] <= wr_qty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_rec_o <= rec_mem[rd_addr_i];
    rd_qty_o <= qty_mem[rd_addr_i];
  end

endmodule

// ----- hdl/lom_scan_unit.sv -----
// shared compare unit: keeps the best match (or oldest id hit) and the first
// free slot over one pass through the slots; depends on lom_pkg
module lom_scan_unit #(
  parameter int unsigned IdxW = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lom_pkg::lom_scan_ctrl_t ctrl_i,
  input  logic [63:0]            order_id_i,
  input  logic [31:0]            limit_i,
  input  logic [31:0]            arrival_now_i,
  input  logic                   slot_valid_i,
  input  logic [IdxW-1:0]        slot_idx_i,
  input  lom_pkg::lom_slot_rec_t slot_rec_i,
  input  logic [31:0]            slot_qty_i,
  output logic                   found_o,
  output logic [IdxW-1:0]        best_idx_o,
  output logic                   best_side_o,
  output logic [31:0]            best_qty_o,
  output logic                   free_found_o,
  output logic [IdxW-1:0]        free_idx_o
);
  import lom_pkg::*;

  logic            found_q, found_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            side_q, side_d;
  logic [31:0]     price_q, price_d;
  logic [31:0]     qty_q, qty_d;
  logic [31:0]     arr_q, arr_d;
  logic            free_found_q, free_found_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;

  logic [31:0] age_slot, age_best;
  logic        eligible, better, take;

  assign age_slot = arrival_now_i - slot_rec_i.arrival;
  assign age_best = arrival_now_i - arr_q;

  always_comb begin
    eligible = 1'b0;
    better   = 1'b0;
    if (ctrl_i.cancel) begin
      eligible = slot_valid_i && (slot_rec_i.order_id == order_id_i);
      better   = age_slot > age_best;
    end else if (ctrl_i.sell) begin
      eligible = slot_valid_i && (slot_rec_i.price != 32'd0) && !slot_rec_i.side &&
                 (slot_rec_i.price >= limit_i);
      better   = (slot_rec_i.price > price_q) ||
                 ((slot_rec_i.price == price_q) && (age_slot > age_best));
    end else begin
      eligible = slot_valid_i && (slot_rec_i.price != 32'd0) && slot_rec_i.side &&
                 (slot_rec_i.price <= limit_i);
      better   = (slot_rec_i.price < price_q) ||
                 ((slot_rec_i.price == price_q) && (age_slot > age_best));
    end
    take = ctrl_i.cmp_en && eligible && (!found_q || better);
  end

  always_comb begin
    found_d      = found_q;
    idx_d        = idx_q;
    side_d       = side_q;
    price_d      = price_q;
    qty_d        = qty_q;
    arr_d        = arr_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    if (ctrl_i.clear) begin
      found_d      = 1'b0;
      free_found_d = 1'b0;
    end else begin
      if (take) begin
        found_d = 1'b1;
        idx_d   = slot_idx_i;
        side_d  = slot_rec_i.side;
        price_d = slot_rec_i.price;
        qty_d   = slot_qty_i;
        arr_d   = slot_rec_i.arrival;
      end
      if (ctrl_i.cmp_en && !slot_valid_i && !free_found_q) begin
        free_found_d = 1'b1;
        free_idx_d   = slot_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      found_q      <= found_d;
      free_found_q <= free_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    side_q     <= side_d;
    price_q    <= price_d;
    qty_q      <= qty_d;
    arr_q      <= arr_d;
    free_idx_q <= free_idx_d;
  end

  assign found_o      = found_q;
  assign best_idx_o   = idx_q;
  assign best_side_o  = side_q;
  assign best_qty_o   = qty_q;
  assign free_found_o = free_found_q;
  assign free_idx_o   = free_idx_q;

endmodule

// ----- hdl/limit_order_matcher_unit.sv -----
// top level of the limit order matcher: sequencer, valid bits, side counts,
// result register; depends on lom_pkg, lom_slot_mem, lom_scan_unit
//
// usage
// - input channel in_valid_i / in_ready_o / in_item_i: buy, sell or cancel
// - output channel out_valid_o / out_ready_i / out_item_o: one result per item
// - every search is one pass through all ORDER_SLOTS slots, one slot a cycle,
//   through the single slot memory read port and the shared compare unit
// - each pass is followed by a decision step
// - a cancel makes one pass, then its decision, then the result
// - an add with k trades makes k + 1 passes, at most
//   k = ORDER_SLOTS; an add that ends filled skips the final pass
// - zero quantity adds and the unused func code go straight to the result
// - in_ready_o is high only while no item is in work
// - the result waits in an output register; a new item can be taken while the
//   receiver stalls, and its result waits until the register is free
// - reset clears every slot valid bit, the side counts and the arrival stamp
//   counter at once; no clearing pass is needed
module limit_order_matcher_unit #(
  parameter int unsigned ORDER_SLOTS = lom_pkg::OrderSlotsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lom_pkg::lom_in_item_t in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lom_pkg::lom_out_item_t out_item_o
);
  import lom_pkg::*;

  localparam int unsigned IdxW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(ORDER_SLOTS + 1);
  localparam int unsigned SatW = (CntW > CountOutW) ? CntW : CountOutW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ORDER_SLOTS - 1);

  function automatic logic [CountOutW-1:0] sat_count(input logic [CntW-1:0] v);
    logic [SatW-1:0] w;
    w = SatW'(v);
    if (w > SatW'(CountMax)) begin
      return CountMax;
    end
    return w[CountOutW-1:0];
  endfunction

  lom_state_e state_q, state_d;

  // item in work
  logic [1:0]      func_q, func_d;
  logic [63:0]     id_q, id_d;
  logic [31:0]     limit_q, limit_d;
  logic [31:0]     left_q, left_d;
  logic [31:0]     filled_q, filled_d;
  logic [31:0]     rested_q, rested_d;
  logic [CntW-1:0] trades_q, trades_d;
  lom_status_e     status_q, status_d;

  // book state
  logic [ORDER_SLOTS-1:0] valid_q, valid_d;
  logic [CntW-1:0]        bids_q, bids_d;
  logic [CntW-1:0]        asks_q, asks_d;
  logic [31:0]            arrival_q, arrival_d;

  // pass addressing: issue stage, and a compare stage in the cycle after it
  logic [IdxW-1:0] scan_idx_q, scan_idx_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_idx_q;

  // result register
  logic          out_vld_q, out_vld_d;
  lom_out_item_t out_q, out_d;

  // memory and compare unit wiring
  lom_slot_rec_t  rd_rec, wr_rec;
  logic [31:0]    rd_qty, wr_qty;
  logic [IdxW-1:0] wr_addr;
  logic           wr_rec_en, wr_qty_en;
  lom_scan_ctrl_t scan_ctrl;
  logic           best_found, best_side, free_found;
  logic [IdxW-1:0] best_idx, free_idx;
  logic [31:0]    best_qty;

  logic        is_add, start_scan, accept, out_free;
  logic [31:0] trade_qty, left_after;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_vld_q || out_ready_i;
  assign is_add     = (func_q == FUNC_BUY) || (func_q == FUNC_SELL);

  // trade size is the smaller of incoming remainder and resting quantity
  assign trade_qty  = (left_q < best_qty) ? left_q : best_qty;
  assign left_after = left_q - trade_qty;

  lom_slot_mem #(
    .Depth(ORDER_SLOTS),
    .IdxW (IdxW)
  ) u_mem (
    .clk_i      (clk_i),
    .rd_addr_i  (scan_idx_q),
    .rd_rec_o   (rd_rec),
    .rd_qty_o   (rd_qty),
    .wr_addr_i  (wr_addr),
    .wr_rec_en_i(wr_rec_en),
    .wr_rec_i   (wr_rec),
    .wr_qty_en_i(wr_qty_en),
    .wr_qty_i   (wr_qty)
  );

  assign scan_ctrl.clear  = start_scan;
  assign scan_ctrl.cmp_en = cmp_vld_q;
  assign scan_ctrl.cancel = (func_q == FUNC_CANCEL);
  assign scan_ctrl.sell   = (func_q == FUNC_SELL);

  lom_scan_unit #(
    .IdxW(IdxW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (scan_ctrl),
    .order_id_i   (id_q),
    .limit_i      (limit_q),
    .arrival_now_i(arrival_q),
    .slot_valid_i (valid_q[cmp_idx_q]),
    .slot_idx_i   (cmp_idx_q),
    .slot_rec_i   (rd_rec),
    .slot_qty_i   (rd_qty),
    .found_o      (best_found),
    .best_idx_o   (best_idx),
    .best_side_o  (best_side),
    .best_qty_o   (best_qty),
    .free_found_o (free_found),
    .free_idx_o   (free_idx)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_item_i.func == FUNC_CANCEL) begin
            state_d = ST_SCAN;
          end else if ((in_item_i.func == FUNC_BUY || in_item_i.func == FUNC_SELL) &&
                       in_item_i.order_quantity != 32'd0) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        if (scan_idx_q == LastIdx) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_d = ST_DECIDE;
      ST_DECIDE: begin
        // another pass only after a trade that leaves a remainder
        if (is_add && best_found && left_after != 32'd0) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    func_d     = func_q;
    id_d       = id_q;
    limit_d    = limit_q;
    left_d     = left_q;
    filled_d   = filled_q;
    rested_d   = rested_q;
    trades_d   = trades_q;
    status_d   = status_q;
    valid_d    = valid_q;
    bids_d     = bids_q;
    asks_d     = asks_q;
    arrival_d  = arrival_q;
    scan_idx_d = scan_idx_q;
    cmp_vld_d  = 1'b0;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_d      = out_q;
    start_scan = 1'b0;
    wr_addr    = best_idx;
    wr_rec_en  = 1'b0;
    wr_qty_en  = 1'b0;
    wr_qty     = best_qty - trade_qty;
    wr_rec.side     = scan_ctrl.sell;
    wr_rec.price    = limit_q;
    wr_rec.order_id = id_q;
    wr_rec.arrival  = arrival_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_d     = in_item_i.func;
          id_d       = in_item_i.order_id;
          limit_d    = in_item_i.limit_price;
          left_d     = in_item_i.order_quantity;
          filled_d   = 32'd0;
          rested_d   = 32'd0;
          trades_d   = '0;
          status_d   = STATUS_ADD_DONE;
          scan_idx_d = '0;
          start_scan = 1'b1;
        end
      end
      ST_SCAN: begin
        cmp_vld_d = 1'b1;
        if (scan_idx_q != LastIdx) begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      ST_SCAN_END: begin
        scan_idx_d = '0;
      end
      ST_DECIDE: begin
        if (!is_add) begin
          // cancel of the oldest entry carrying the id
          if (best_found) begin
            valid_d[best_idx] = 1'b0;
            if (best_side) begin
              asks_d = asks_q - 1'b1;
            end else begin
              bids_d = bids_q - 1'b1;
            end
            status_d = STATUS_CANCEL_FOUND;
          end else begin
            status_d = STATUS_CANCEL_MISSING;
          end
        end else if (best_found) begin
          // one trade against the best resting order
          wr_qty_en = 1'b1;
          left_d    = left_after;
          filled_d  = filled_q + trade_qty;
          trades_d  = trades_q + 1'b1;
          if (best_qty == trade_qty) begin
            valid_d[best_idx] = 1'b0;
            if (best_side) begin
              asks_d = asks_q - 1'b1;
            end else begin
              bids_d = bids_q - 1'b1;
            end
          end
          start_scan = (left_after != 32'd0);
        end else if (free_found) begin
          // remainder rests in the lowest free slot
          wr_addr   = free_idx;
          wr_rec_en = 1'b1;
          wr_qty_en = 1'b1;
          wr_qty    = left_q;
          valid_d[free_idx] = 1'b1;
          if (scan_ctrl.sell) begin
            asks_d = asks_q + 1'b1;
          end else begin
            bids_d = bids_q + 1'b1;
          end
          arrival_d = arrival_q + 32'd1;
          rested_d  = left_q;
        end else begin
          status_d = STATUS_BOOK_FULL;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_vld_d             = 1'b1;
          out_d.status          = status_q;
          out_d.filled_quantity = filled_q;
          out_d.rested_quantity = rested_q;
          out_d.trade_count     = sat_count(trades_q);
          out_d.bid_count       = sat_count(bids_q);
          out_d.ask_count       = sat_count(asks_q);
        end
      end
      default: begin
        out_vld_d = out_vld_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      bids_q     <= '0;
      asks_q     <= '0;
      arrival_q  <= 32'd0;
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      bids_q     <= bids_d;
      asks_q     <= asks_d;
      arrival_q  <= arrival_d;
      scan_idx_q <= scan_idx_d;
      cmp_vld_q  <= cmp_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    id_q      <= id_d;
    limit_q   <= limit_d;
    left_q    <= left_d;
    filled_q  <= filled_d;
    rested_q  <= rested_d;
    trades_q  <= trades_d;
    status_q  <= status_d;
    cmp_idx_q <= scan_idx_q;
    out_q     <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

// ----- bench/limit_order_matcher_unit_test.sv -----
// testbench for limit_order_matcher_unit: directed table, book fill, then random
// orders; each result checked against a fixed value or a price-time priority book model
// depends on lom_pkg and the limit_order_matcher_unit rtl
`timescale 1ns / 100ps

module limit_order_matcher_unit_test;
  import lom_pkg::*;

  localparam int unsigned Slots = 256;
  localparam int unsigned NumRandom = 974;
  localparam longint unsigned CycleLimit = 64'd120_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  lom_in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  lom_out_item_t out_item_o;

  limit_order_matcher_unit #(.ORDER_SLOTS(Slots)) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o(out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model of the book
  logic        book_live [Slots];
  logic        book_sell [Slots];
  logic [31:0] book_price [Slots];
  logic [31:0] book_qty [Slots];
  logic [63:0] book_id [Slots];
  logic [31:0] book_stamp [Slots];
  logic [31:0] stamp_next;

  lom_out_item_t pending_results[$];
  int errors = 0;
  bit stim_done = 1'b0;
  longint unsigned cycles = 0;
  bit long_hold = 1'b0;

  function automatic void queue_expect(lom_out_item_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic logic [31:0] age(int s);
    return stamp_next - book_stamp[s];
  endfunction

  function automatic logic [8:0] sat9(int v);
    return (v > 511) ? 9'd511 : v[8:0];
  endfunction

  function automatic int best_counterpart(bit sell, logic [31:0] lim);
    int best;
    best = -1;
    for (int s = 0; s < Slots; s++) begin
      if (!book_live[s] || book_price[s] == 0) continue;
      if (sell) begin
        if (book_sell[s] || book_price[s] < lim) continue;
      end else begin
        if (!book_sell[s] || book_price[s] > lim) continue;
      end
      if (best < 0) begin
        best = s;
      end else if ((sell ? book_price[s] > book_price[best]
                         : book_price[s] < book_price[best]) ||
                   (book_price[s] == book_price[best] && age(s) > age(best))) begin
        best = s;
      end
    end
    return best;
  endfunction

  function automatic lom_out_item_t match_order(lom_in_item_t it);
    lom_out_item_t r;
    int found, m, trades, bids, asks;
    logic [31:0] left, t;
    r = '0;
    r.status = STATUS_ADD_DONE;
    trades = 0;
    if (it.func == FUNC_CANCEL) begin
      found = -1;
      for (int s = 0; s < Slots; s++)
        if (book_live[s] && book_id[s] == it.order_id &&
            (found < 0 || age(s) > age(found))) found = s;
      if (found >= 0) begin
        book_live[found] = 1'b0;
        r.status = STATUS_CANCEL_FOUND;
      end else begin
        r.status = STATUS_CANCEL_MISSING;
      end
    end else if (it.func == FUNC_BUY || it.func == FUNC_SELL) begin
      left = it.order_quantity;
      while (left > 0) begin
        m = best_counterpart(it.func == FUNC_SELL, it.limit_price);
        if (m < 0) break;
        t = (left < book_qty[m]) ? left : book_qty[m];
        left -= t;
        r.filled_quantity += t;
        book_qty[m] -= t;
        if (book_qty[m] == 0) book_live[m] = 1'b0;
        trades++;
      end
      r.trade_count = sat9(trades);
      if (left > 0) begin
        found = -1;
        for (int s = 0; s < Slots; s++)
          if (!book_live[s] && found < 0) found = s;
        if (found < 0) begin
          r.status = STATUS_BOOK_FULL;
        end else begin
          book_live[found] = 1'b1;
          book_sell[found] = (it.func == FUNC_SELL);
          book_price[found] = it.limit_price;
          book_qty[found] = left;
          book_id[found] = it.order_id;
          book_stamp[found] = stamp_next;
          stamp_next++;
          r.rested_quantity = left;
        end
      end
    end
    bids = 0;
    asks = 0;
    for (int s = 0; s < Slots; s++)
      if (book_live[s]) begin
        if (book_sell[s]) asks++;
        else bids++;
      end
    r.bid_count = sat9(bids);
    r.ask_count = sat9(asks);
    return r;
  endfunction

  // directed table; fixed result used where it is obvious, else the model
  typedef struct {
    lom_in_item_t  item;
    bit            fixed;
    lom_out_item_t result;
  } directed_row_t;

  directed_row_t plan[$];

  function automatic lom_in_item_t mk(logic [1:0] f, logic [63:0] id,
                                      logic [31:0] p, logic [31:0] q);
    lom_in_item_t it;
    it.func = f;
    it.order_id = id;
    it.limit_price = p;
    it.order_quantity = q;
    return it;
  endfunction

  task automatic add_row(lom_in_item_t it, bit fx, lom_out_item_t r);
    directed_row_t d;
    d.item = it;
    d.fixed = fx;
    d.result = r;
    plan = {plan, d};
  endtask

  function automatic lom_out_item_t res(logic [1:0] st, logic [31:0] fq,
                                        logic [31:0] rq, int tc, int bc, int ac);
    lom_out_item_t r;
    r.status = st;
    r.filled_quantity = fq;
    r.rested_quantity = rq;
    r.trade_count = tc[8:0];
    r.bid_count = bc[8:0];
    r.ask_count = ac[8:0];
    return r;
  endfunction

  // random order with prices clustered so crossing is common
  function automatic lom_in_item_t random_order();
    lom_in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.func = (pick < 42) ? FUNC_BUY : (pick < 84) ? FUNC_SELL :
              (pick < 97) ? FUNC_CANCEL : FUNC_UNUSED;
    it.order_id = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                              : 64'($urandom_range(0, 40));
    case ($urandom_range(0, 9))
      0: it.limit_price = $urandom;
      1: it.limit_price = 32'hFFFF_FFFF;
      2: it.limit_price = 32'd0;
      default: it.limit_price = 32'd1000 + $urandom_range(0, 20);
    endcase
    case ($urandom_range(0, 9))
      0: it.order_quantity = $urandom;
      1: it.order_quantity = 32'd0;
      default: it.order_quantity = $urandom_range(1, 60);
    endcase
    return it;
  endfunction

  // offer one item, hold it until accepted
  task automatic send_item(lom_in_item_t it);
    in_item_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_gap();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 8)) @(posedge clk_i);
  endtask

  // sender: accepted items go to the model at acceptance time
  initial begin
    lom_in_item_t it;
    int burst;
    for (int s = 0; s < Slots; s++) book_live[s] = 1'b0;
    stamp_next = '0;
    add_row(mk(FUNC_CANCEL, 64'd5, 0, 0), 1, res(STATUS_CANCEL_MISSING, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_BUY, 64'd1, 32'd1000, 32'd0), 1, res(STATUS_ADD_DONE, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_UNUSED, 64'd1, 32'd1000, 32'd9), 1,
            res(STATUS_ADD_DONE, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_BUY, 64'd1, 32'd1000, 32'd10), 1, res(STATUS_ADD_DONE, 0, 10, 0, 1, 0));
    add_row(mk(FUNC_BUY, 64'd2, 32'd0, 32'd7), 1, res(STATUS_ADD_DONE, 0, 7, 0, 2, 0));
    add_row(mk(FUNC_SELL, 64'd3, 32'd0, 32'd4), 0, '0);
    add_row(mk(FUNC_SELL, 64'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, '0);
    add_row(mk(FUNC_BUY, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd5), 0, '0);
    add_row(mk(FUNC_BUY, 64'd1, 32'd1000, 32'd3), 0, '0);
    add_row(mk(FUNC_CANCEL, 64'd1, 0, 0), 0, '0);
    add_row(mk(FUNC_CANCEL, 64'd1, 0, 0), 0, '0);
    add_row(mk(FUNC_SELL, 64'd6, 32'd900, 32'd20), 0, '0);
    add_row(mk(FUNC_CANCEL, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0), 0, '0);
    add_row(mk(FUNC_BUY, 64'd7, 32'd5000, 32'hFFFF_FFFF), 0, '0);
    add_row(mk(FUNC_SELL, 64'd8, 32'd1, 32'd2), 0, '0);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[i]) begin
      send_item(plan[i].item);
      if (plan[i].fixed) begin
        queue_expect(plan[i].result);
        void'(match_order(plan[i].item));
      end else begin
        queue_expect(match_order(plan[i].item));
      end
    end
    // fill the book past full to reach the refused remainder case
    for (int i = 0; i < Slots + 4; i++) begin
      it = mk(FUNC_BUY, 64'(100 + i), 32'd10 + i[7:0], 32'd1);
      send_item(it);
      queue_expect(match_order(it));
    end
    it = mk(FUNC_SELL, 64'd9, 32'd1, 32'd400);
    send_item(it);
    queue_expect(match_order(it));
    send_gap();
    for (int n = 0; n < NumRandom;) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && n < NumRandom; b++, n++) begin
        it = random_order();
        send_item(it);
        queue_expect(match_order(it));
      end
      if ($urandom_range(0, 2) != 0) send_gap();
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: stall pattern plus one long hold while items keep coming
  initial begin
    int hold;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (!long_hold && cycles > 20000) begin
        long_hold = 1'b1;
        hold = 3000;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ((cycles / 97) % 3 == 0) ? ($urandom_range(0, 3) == 0)
                                                : ($urandom_range(0, 4) != 0);
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    lom_out_item_t want;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, out_item_o.status);
          errors++;
        end
        if (out_item_o.filled_quantity !== want.filled_quantity) begin
          $error("filled_quantity exp %0d got %0d", want.filled_quantity,
                 out_item_o.filled_quantity);
          errors++;
        end
        if (out_item_o.rested_quantity !== want.rested_quantity) begin
          $error("rested_quantity exp %0d got %0d", want.rested_quantity,
                 out_item_o.rested_quantity);
          errors++;
        end
        if (out_item_o.trade_count !== want.trade_count) begin
          $error("trade_count exp %0d got %0d", want.trade_count,
                 out_item_o.trade_count);
          errors++;
        end
        if (out_item_o.bid_count !== want.bid_count) begin
          $error("bid_count exp %0d got %0d", want.bid_count, out_item_o.bid_count);
          errors++;
        end
        if (out_item_o.ask_count !== want.ask_count) begin
          $error("ask_count exp %0d got %0d", want.ask_count, out_item_o.ask_count);
          errors++;
        end
      end
    end
  end

  // end of run: drain, settle, report; or time out
  initial begin
    wait (stim_done && pending_results.size() == 0);
    repeat (2 * Slots + 20) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0)
      $display("limit_order_matcher_unit: match");
    else
      $display("limit_order_matcher_unit: mismatch");
    $finish;
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("limit_order_matcher_unit: mismatch");
    $finish;
  end

endmodule
